>>> rtl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Types and constants shared by the typed binary ALU front end, command
// queue and execution back end.
// ----------------------------------------------------------------------------
package tba_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_MUL = 4'd1,
		OP_DIV = 4'd2,
		OP_SUB = 4'd3,
		OP_XOR = 4'd4,
		OP_MOD = 4'd5,
		OP_EQ  = 4'd6,
		OP_GT  = 4'd7,
		OP_LT  = 4'd8,
		OP_GE  = 4'd9,
		OP_NE  = 4'd10,
		OP_AND = 4'd11,
		OP_LE  = 4'd12,
		OP_OR  = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		TAG_INT  = 2'd0,
		TAG_CHAR = 2'd1,
		TAG_NULL = 2'd2
	} tag_t;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_NULL  = 2'd1,
		ST_ERROR = 2'd2,
		ST_UNSUP = 2'd3
	} status_t;

	// Execution class chosen by the front end
	typedef enum logic [2:0] {
		K_FIXED = 3'd0,
		K_ADD   = 3'd1,
		K_MUL   = 3'd2,
		K_SUB   = 3'd3,
		K_XOR   = 3'd4,
		K_DIV   = 3'd5,
		K_MOD   = 3'd6,
		K_CMP   = 3'd7
	} kind_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIV_STEPS = DATA_W;
	localparam int unsigned STEP_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [3:0]               operation;
		logic [1:0]               left_type;
		logic [1:0]               right_type;
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;
	} in_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] result_value;
	} out_t;

	typedef struct packed {
		kind_t                    kind;
		logic [3:0]               operation;
		status_t                  status;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} cmd_t;

endpackage

>>> rtl/typed_binary_alu_top.sv
// ----------------------------------------------------------------------------
// typed_binary_alu_top
// Typed SQL binary operation unit: a front end that classifies each item by
// its tags, a command queue, and a back end that runs the arithmetic.
//
//   channel   direction  handshake     payload
//   item      in         push / full   tba_pkg::in_t
//   result    out        pop / empty   tba_pkg::out_t
//
// Add, sub, xor, multiply, compare and every null, error or unsupported
// outcome skip the divider: one item per cycle while the result queue has
// room. Div and mod run on a radix-2 sequential divider that hands its
// result to the result queue when done, and later items wait behind it.
// A result reaches the result ports after its item has been written into
// the command queue and then into the result queue.
// arst_n empties both queues and idles the divider; no clearing pass.
// full rises only when the command queue holds QUEUE_DEPTH items; a stalled
// pop backs up through the two-entry result queue into the command queue.
// ----------------------------------------------------------------------------
module typed_binary_alu_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tba_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output tba_pkg::out_t result
);
	import tba_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic head_empty;
	logic head_pop;

	tba_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	tba_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.full   (full),
		.pop    (head_pop),
		.rd_cmd (head_cmd),
		.empty  (head_empty)
	);

	tba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (head_empty),
		.cmd_pop   (head_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> rtl/tba_front.sv
// ----------------------------------------------------------------------------
// tba_front
// Classifies an incoming item by its type tags and operation: settles every
// null, error and unsupported outcome and names the unit that runs the rest.
// ----------------------------------------------------------------------------
module tba_front (
	input  tba_pkg::in_t  item,
	output tba_pkg::cmd_t cmd
);
	import tba_pkg::*;

	logic both_int;
	logic is_arith;
	logic is_logic;

	assign both_int = (item.left_type == TAG_INT) && (item.right_type == TAG_INT);
	assign is_arith = item.operation <= OP_MOD;
	assign is_logic = (item.operation >= OP_EQ) && (item.operation <= OP_OR);

	always_comb begin
		cmd.kind      = K_FIXED;
		cmd.operation = item.operation;
		cmd.status    = ST_VALID;
		cmd.a         = item.left_value;
		cmd.b         = item.right_value;
		if (item.left_type != item.right_type) begin
			cmd.status = ST_ERROR;
		end else if (is_arith) begin
			if (!both_int) begin
				cmd.status = ST_NULL;
			end else begin
				unique case (item.operation)
					OP_ADD: cmd.kind = K_ADD;
					OP_MUL: cmd.kind = K_MUL;
					OP_SUB: cmd.kind = K_SUB;
					OP_XOR: cmd.kind = K_XOR;
					OP_DIV, OP_MOD: begin
						// zero divisor never reaches the divider
						if (item.right_value == '0)
							cmd.status = ST_ERROR;
						else
							cmd.kind = (item.operation == OP_DIV) ? K_DIV : K_MOD;
					end
					default: cmd.status = ST_ERROR;
				endcase
			end
		end else if (is_logic) begin
			if (both_int)
				cmd.kind = K_CMP;
			else if (item.left_type == TAG_CHAR)
				cmd.status = ST_UNSUP;
			else
				cmd.status = ST_NULL;
		end else begin
			cmd.status = ST_ERROR;
		end
	end

endmodule

>>> rtl/tba_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tba_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tba_cmd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tba_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output tba_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import tba_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/tba_back.sv
// ----------------------------------------------------------------------------
// tba_back
// Executes queued commands: combinational add, sub, xor, multiply and
// compare, a radix-2 sequential divider for div and mod, and a two-entry
// result queue towards the consumer.
// ----------------------------------------------------------------------------
module tba_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tba_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output tba_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);
	import tba_pkg::*;

	localparam int unsigned OQ_DEPTH = 2;

	// result queue
	out_t       oq_q [OQ_DEPTH];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_push;
	logic       oq_pop;
	logic       oq_space;
	out_t       oq_din;

	// divider
	logic              div_busy_q;
	logic              div_done_q;
	logic              div_mod_q;
	logic              div_qneg_q;
	logic              div_rneg_q;
	logic [STEP_W-1:0] div_step_q;
	logic [DATA_W-1:0] div_dvd_q;
	logic [DATA_W-1:0] div_rem_q;
	logic [DATA_W-1:0] div_dsr_q;
	logic [DATA_W:0]   div_trial;
	logic              div_start;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] div_res;

	logic              head_ok;
	logic              issue_fast;
	logic [DATA_W-1:0] fast_val;
	logic [DATA_W-1:0] prod;
	logic              cmp_bit;

	assign oq_pop   = pop && (oq_cnt_q != '0);
	assign oq_space = (oq_cnt_q != 2'(OQ_DEPTH)) || oq_pop;
	assign empty    = oq_cnt_q == '0;
	assign result   = oq_q[oq_rd_q];

	// the divider holds issue until its result has left for the queue
	assign head_ok    = !cmd_empty && !div_busy_q && !div_done_q;
	assign div_start  = head_ok && ((cmd.kind == K_DIV) || (cmd.kind == K_MOD));
	assign issue_fast = head_ok && !div_start && oq_space;
	assign cmd_pop    = div_start || issue_fast;

	assign prod = DATA_W'(cmd.a * cmd.b);

	always_comb begin
		cmp_bit = 1'b0;
		case (cmd.operation)
			OP_EQ:   cmp_bit = cmd.a == cmd.b;
			OP_GT:   cmp_bit = cmd.a > cmd.b;
			OP_LT:   cmp_bit = cmd.a < cmd.b;
			OP_GE:   cmp_bit = cmd.a >= cmd.b;
			OP_NE:   cmp_bit = cmd.a != cmd.b;
			OP_AND:  cmp_bit = (cmd.a != '0) && (cmd.b != '0);
			OP_LE:   cmp_bit = cmd.a <= cmd.b;
			default: cmp_bit = (cmd.a != '0) || (cmd.b != '0);
		endcase
	end

	always_comb begin
		fast_val = '0;
		unique case (cmd.kind)
			K_ADD:   fast_val = cmd.a + cmd.b;
			K_MUL:   fast_val = prod;
			K_SUB:   fast_val = cmd.a - cmd.b;
			K_XOR:   fast_val = cmd.a ^ cmd.b;
			K_CMP:   fast_val = {{(DATA_W-1){1'b0}}, cmp_bit};
			default: fast_val = '0;
		endcase
	end

	assign div_quo = div_qneg_q ? (~div_dvd_q + 1'b1) : div_dvd_q;
	assign div_res = div_mod_q ? (div_rneg_q ? (~div_rem_q + 1'b1) : div_rem_q) : div_quo;

	always_comb begin
		if (div_done_q) begin
			oq_push             = oq_space;
			oq_din.status       = ST_VALID;
			oq_din.result_value = div_res;
		end else begin
			oq_push             = issue_fast;
			oq_din.status       = cmd.status;
			oq_din.result_value = fast_val;
		end
	end

	assign div_trial = {div_rem_q, div_dvd_q[DATA_W-1]} - {1'b0, div_dsr_q};

	// divider datapath
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_mod_q  <= cmd.kind == K_MOD;
			div_qneg_q <= cmd.a[DATA_W-1] ^ cmd.b[DATA_W-1];
			div_rneg_q <= cmd.a[DATA_W-1];
			div_dvd_q  <= cmd.a[DATA_W-1] ? (~cmd.a + 1'b1) : cmd.a;
			div_dsr_q  <= cmd.b[DATA_W-1] ? (~cmd.b + 1'b1) : cmd.b;
			div_rem_q  <= '0;
		end else if (div_busy_q) begin
			if (!div_trial[DATA_W]) begin
				div_rem_q <= div_trial[DATA_W-1:0];
				div_dvd_q <= {div_dvd_q[DATA_W-2:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[DATA_W-2:0], div_dvd_q[DATA_W-1]};
				div_dvd_q <= {div_dvd_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_step_q <= '0;
		end else begin
			if (div_start) begin
				div_busy_q <= 1'b1;
				div_step_q <= STEP_W'(DIV_STEPS - 1);
			end else if (div_busy_q) begin
				div_step_q <= div_step_q - 1'b1;
				if (div_step_q == '0) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end else if (div_done_q && oq_space) begin
				div_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_q[oq_wr_q] <= oq_din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push)
				oq_wr_q <= ~oq_wr_q;
			if (oq_pop)
				oq_rd_q <= ~oq_rd_q;
			if (oq_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_pop && !oq_push)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	a_div_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy_q && div_done_q))
		else $error("divider busy and done together");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= 2'(OQ_DEPTH))
		else $error("result queue overflow");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy_q && (div_step_q == STEP_W'(DIV_STEPS - 1)))
		else $error("divider did not start");

	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q && (div_step_q == '0) |=> div_done_q)
		else $error("divider did not finish");

	a_no_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy_q || div_done_q) |-> !cmd_pop)
		else $error("command issued while divider owns the back end");

endmodule

>>> test/typed_binary_alu_top_test.sv
// ----------------------------------------------------------------------------
// typed_binary_alu_top_test
// Self-checking bench for the typed binary ALU. A directed table covers the
// operand extremes, every operation, tag mismatches, spare tags and opcodes,
// zero divisors and the most negative quotient. About 1900 random beats
// follow. Every result beat is compared, field by field, against a
// prediction made when its item was pushed. Push and pop both idle at random.
// ----------------------------------------------------------------------------
module typed_binary_alu_top_test;
	import tba_pkg::*;

	localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX   = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINUS_ONE = -32'sd1;
	localparam logic [3:0]         OP_SPARE_LO = 4'd14;
	localparam logic [3:0]         OP_SPARE_HI = 4'd15;
	localparam logic [1:0]         TAG_SPARE   = 2'd3;
	localparam int                 RANDOM_BEATS = 1900;
	localparam int                 CYCLE_LIMIT  = 400000;
	localparam int                 DRAIN_CYCLES = 80;

	typedef struct {
		in_t  stim;
		bit   typed;
		out_t outcome;
	} vector_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  push = 1'b0;
	logic  full;
	in_t   item = '0;
	logic  empty;
	logic  pop = 1'b0;
	out_t  result;

	out_t  expected_outcomes[$];
	int    mismatch_count = 0;
	int    cycle_count = 0;
	bit    no_idle = 1'b0;

	typed_binary_alu_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic in_t beat_of(logic [3:0] op, logic [1:0] lt, logic [1:0] rt,
			logic signed [31:0] lv, logic signed [31:0] rv);
		in_t b;
		b.operation   = op;
		b.left_type   = lt;
		b.right_type  = rt;
		b.left_value  = lv;
		b.right_value = rv;
		return b;
	endfunction

	function automatic out_t predict_outcome(in_t b);
		out_t               o;
		logic signed [31:0] a;
		logic signed [31:0] d;
		bit                 both_int;
		a        = b.left_value;
		d        = b.right_value;
		both_int = (b.left_type == TAG_INT) && (b.right_type == TAG_INT);
		o        = '{ST_VALID, 32'sd0};
		if (b.left_type != b.right_type) begin
			o.status = ST_ERROR;
		end else if (b.operation <= OP_MOD) begin
			if (!both_int) begin
				o.status = ST_NULL;
			end else begin
				case (op_t'(b.operation))
					OP_ADD: o.result_value = a + d;
					OP_MUL: o.result_value = a * d;
					OP_SUB: o.result_value = a - d;
					OP_XOR: o.result_value = a ^ d;
					default: begin
						if (d == 32'sd0)
							o.status = ST_ERROR;
						else if (a == INT_MIN && d == MINUS_ONE)
							o.result_value = (b.operation == OP_DIV) ? INT_MIN : 32'sd0;
						else if (b.operation == OP_DIV)
							o.result_value = a / d;
						else
							o.result_value = a % d;
					end
				endcase
			end
		end else if (b.operation <= OP_OR) begin
			if (both_int) begin
				case (op_t'(b.operation))
					OP_EQ:   o.result_value = {31'd0, a == d};
					OP_GT:   o.result_value = {31'd0, a > d};
					OP_LT:   o.result_value = {31'd0, a < d};
					OP_GE:   o.result_value = {31'd0, a >= d};
					OP_NE:   o.result_value = {31'd0, a != d};
					OP_AND:  o.result_value = {31'd0, a != 0 && d != 0};
					OP_LE:   o.result_value = {31'd0, a <= d};
					default: o.result_value = {31'd0, a != 0 || d != 0};
				endcase
			end else if (b.left_type == TAG_CHAR) begin
				o.status = ST_UNSUP;
			end else begin
				o.status = ST_NULL;
			end
		end else begin
			o.status = ST_ERROR;
		end
		return o;
	endfunction

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0:       return INT_MIN;
			1:       return INT_MAX;
			2:       return 32'sd0;
			3:       return MINUS_ONE;
			4:       return 32'sd1;
			5, 6:    return $signed($urandom_range(0, 32)) - 32'sd16;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t random_beat();
		int          pick;
		logic [1:0]  tag;
		pick = $urandom_range(0, 99);
		tag  = 2'($urandom_range(0, 3));
		// mostly well-formed integer work, then equal tags, then anything, then spare opcodes
		if (pick < 75)
			return beat_of(4'($urandom_range(0, 13)), TAG_INT, TAG_INT,
				pick_operand(), pick_operand());
		if (pick < 85)
			return beat_of(4'($urandom_range(0, 15)), tag, tag,
				pick_operand(), pick_operand());
		if (pick < 95)
			return beat_of(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), $urandom, $urandom);
		return beat_of(4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), tag, tag,
			$urandom, $urandom);
	endfunction

	// Hold push and the item until the beat is taken, then log its outcome.
	task automatic send_beat(in_t b, bit typed, out_t typed_outcome);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 8) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= b;
		do
			@(posedge clk);
		while (full);
		expected_outcomes.push_back(typed ? typed_outcome : predict_outcome(b));
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		push <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		pop <= no_idle || ($urandom_range(0, 99) >= 8);

	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && !empty) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result beat: status %0d value %0d",
					$time, result.status, result.result_value);
				mismatch_count++;
			end else begin
				want = expected_outcomes.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, result.status);
					mismatch_count++;
				end
				if (result.result_value !== want.result_value) begin
					$display("%0t: result_value expected %0d, got %0d",
						$time, want.result_value, result.result_value);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("typed_binary_alu_top_test: errors");
			$finish;
		end
	end

	initial begin
		vector_t vectors[$];
		vectors = '{
			'{beat_of(OP_ADD, TAG_INT, TAG_INT, INT_MAX, 32'sd1), 1'b1,
				out_t'{ST_VALID, INT_MIN}},
			'{beat_of(OP_MUL, TAG_INT, TAG_INT, INT_MIN, MINUS_ONE), 1'b0, '0},
			'{beat_of(OP_DIV, TAG_INT, TAG_INT, INT_MIN, MINUS_ONE), 1'b1,
				out_t'{ST_VALID, INT_MIN}},
			'{beat_of(OP_MOD, TAG_INT, TAG_INT, INT_MIN, MINUS_ONE), 1'b1,
				out_t'{ST_VALID, 32'sd0}},
			'{beat_of(OP_DIV, TAG_INT, TAG_INT, INT_MAX, 32'sd0), 1'b1,
				out_t'{ST_ERROR, 32'sd0}},
			'{beat_of(OP_MOD, TAG_INT, TAG_INT, -32'sd7, 32'sd0), 1'b1,
				out_t'{ST_ERROR, 32'sd0}},
			'{beat_of(OP_SUB, TAG_INT, TAG_INT, INT_MIN, 32'sd1), 1'b1,
				out_t'{ST_VALID, INT_MAX}},
			'{beat_of(OP_XOR, TAG_INT, TAG_INT, MINUS_ONE, 32'sh5555_5555), 1'b0, '0},
			'{beat_of(OP_MOD, TAG_INT, TAG_INT, -32'sd7, 32'sd2), 1'b0, '0},
			'{beat_of(OP_EQ, TAG_INT, TAG_INT, INT_MIN, INT_MIN), 1'b0, '0},
			'{beat_of(OP_GT, TAG_INT, TAG_INT, INT_MIN, INT_MAX), 1'b0, '0},
			'{beat_of(OP_LT, TAG_INT, TAG_INT, MINUS_ONE, 32'sd0), 1'b0, '0},
			'{beat_of(OP_GE, TAG_INT, TAG_INT, INT_MAX, INT_MAX), 1'b0, '0},
			'{beat_of(OP_NE, TAG_INT, TAG_INT, 32'sd0, 32'sd1), 1'b0, '0},
			'{beat_of(OP_AND, TAG_INT, TAG_INT, 32'sd0, MINUS_ONE), 1'b0, '0},
			'{beat_of(OP_LE, TAG_INT, TAG_INT, INT_MAX, INT_MIN), 1'b0, '0},
			'{beat_of(OP_OR, TAG_INT, TAG_INT, 32'sd0, 32'sd0), 1'b0, '0},
			'{beat_of(OP_SPARE_HI, TAG_INT, TAG_CHAR, 32'sd1, 32'sd1), 1'b1,
				out_t'{ST_ERROR, 32'sd0}},
			'{beat_of(OP_SPARE_LO, TAG_INT, TAG_INT, 32'sd3, 32'sd4), 1'b1,
				out_t'{ST_ERROR, 32'sd0}},
			'{beat_of(OP_ADD, TAG_CHAR, TAG_CHAR, 32'sd5, 32'sd6), 1'b1,
				out_t'{ST_NULL, 32'sd0}},
			'{beat_of(OP_EQ, TAG_CHAR, TAG_CHAR, 32'sd5, 32'sd5), 1'b1,
				out_t'{ST_UNSUP, 32'sd0}},
			'{beat_of(OP_OR, TAG_CHAR, TAG_CHAR, 32'sd1, 32'sd0), 1'b1,
				out_t'{ST_UNSUP, 32'sd0}},
			'{beat_of(OP_LT, TAG_NULL, TAG_NULL, 32'sd1, 32'sd2), 1'b1,
				out_t'{ST_NULL, 32'sd0}},
			'{beat_of(OP_GE, TAG_SPARE, TAG_SPARE, INT_MAX, INT_MIN), 1'b1,
				out_t'{ST_NULL, 32'sd0}},
			'{beat_of(OP_DIV, TAG_INT, TAG_NULL, 32'sd9, 32'sd3), 1'b1,
				out_t'{ST_ERROR, 32'sd0}}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (vectors[i])
			send_beat(vectors[i].stim, vectors[i].typed, vectors[i].outcome);
		wait_for_drain();

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			no_idle = (n >= 700 && n < 1000);
			if (n == 1200)
				wait_for_drain();
			send_beat(random_beat(), 1'b0, '0);
		end
		no_idle = 1'b0;
		@(negedge clk);
		push <= 1'b0;

		while (expected_outcomes.size() != 0)
			@(posedge clk);
		// allow stray beats to surface
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("typed_binary_alu_top_test: clean");
		else
			$display("typed_binary_alu_top_test: errors");
		$finish;
	end

endmodule
